/* hdl/sedd_pkg.sv */
// Shared types and constants for the source entropy flood detector.
package sedd_pkg;

  // Field widths of the item and result formats.
  localparam int ADDR_W    = 32;
  localparam int THRESH_W  = 20;
  localparam int MINF_W    = 13;
  localparam int ENT_W     = 20;
  localparam int CONF_W    = 17;
  localparam int TOTAL_W   = 13;
  localparam int DIST_W    = 11;

  // Search lanes: table entries compared per cycle.
  localparam int LANES     = 16;
  localparam int LANE_W    = 4;

  // Log unit: fraction bits before rounding and result width.
  localparam int FRAC_BITS = 17;
  localparam int LOG_W     = 21;
  localparam int EXP_W     = 5;

  // Configuration register reset values.
  localparam logic [THRESH_W-1:0] THRESH_RST = 20'd98304;
  localparam logic [MINF_W-1:0]   MINF_RST   = 13'd10;

  // Register indexes on the configuration port.
  localparam logic REG_THRESH = 1'b0;
  localparam logic REG_MINF   = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic              last_flow;
  } sedd_in_t;

  typedef struct packed {
    logic               alert;
    logic [ADDR_W-1:0]  top_source;
    logic [ENT_W-1:0]   entropy_value;
    logic [CONF_W-1:0]  confidence;
    logic [TOTAL_W-1:0] flow_total;
    logic [DIST_W-1:0]  distinct_sources;
  } sedd_out_t;

  // Head of the item queue as seen by the back end.
  typedef struct packed {
    logic     valid;
    sedd_in_t item;
  } sedd_head_t;

endpackage

/* hdl/sedd_ram.sv */
// Generic single write port RAM with registered read.
module sedd_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                    wdata,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                    rdata
);

  logic [W-1:0] mem [D];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/sedd_log.sv */
// Iterative log2 unit: round(65536*log2 x) by repeated squaring.
module sedd_log
  import sedd_pkg::*;
#(
  parameter int XW = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [XW-1:0]    x,
  output logic             done,
  output logic [LOG_W-1:0] res
);

  typedef enum logic [1:0] {L_IDLE, L_SQ, L_FIN} lstate_t;

  lstate_t              state;
  logic [63:0]          m;
  logic [63:0]          p00, p01, p11;
  logic [1:0]           ph;
  logic [4:0]           iter;
  logic [EXP_W-1:0]     e;
  logic [FRAC_BITS-1:0] frac;
  logic [EXP_W-1:0]     e_calc;
  logic [31:0]          mul_a, mul_b;
  logic [63:0]          prod;
  logic [33:0]          mid;
  logic [63:0]          hi;
  logic [63:0]          sq;
  logic [EXP_W+FRAC_BITS-1:0] rnd;

  // Position of the leading one of the operand.
  always_comb begin
    e_calc = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) begin
        e_calc = EXP_W'(i);
      end
    end
  end

  // One shared 32x32 multiplier for the three partial products.
  always_comb begin
    mul_a = m[31:0];
    mul_b = m[31:0];
    if (ph == 2'd1) begin
      mul_b = m[63:32];
    end else if (ph == 2'd2) begin
      mul_a = m[63:32];
      mul_b = m[63:32];
    end
    prod = 64'(mul_a) * 64'(mul_b);
  end

  // Combine the partial products into the squared Q2.62 mantissa.
  always_comb begin
    mid = 34'(p00[63:32]) + {1'b0, p01[31:0], 1'b0};
    hi  = p11 + {p01[62:32], 1'b0} + {31'b0, p01[63], 32'b0} + 64'(mid[33:32]);
    sq  = {hi[61:0], mid[31:30]};
    rnd = {e, frac} + 1'b1;
  end

  // Sequencer: each squaring step runs three partial products and a combine, seventeen steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            if (x <= XW'(1)) begin
              res  <= '0;
              done <= 1'b1;
            end else begin
              e     <= e_calc;
              m     <= 64'(x) << (6'd62 - 6'(e_calc));
              frac  <= '0;
              ph    <= 2'd0;
              iter  <= '0;
              state <= L_SQ;
            end
          end
        end
        L_SQ: begin
          ph <= ph + 2'd1;
          case (ph)
            2'd0: p00 <= prod;
            2'd1: p01 <= prod;
            2'd2: p11 <= prod;
            default: begin
              if (sq[63]) begin
                m    <= sq >> 1;
                frac <= {frac[FRAC_BITS-2:0], 1'b1};
              end else begin
                m    <= sq;
                frac <= {frac[FRAC_BITS-2:0], 1'b0};
              end
              iter <= iter + 5'd1;
              if (iter == 5'(FRAC_BITS - 1)) begin
                state <= L_FIN;
              end
            end
          endcase
        end
        L_FIN: begin
          res   <= LOG_W'(rnd >> 1);
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

/* hdl/sedd_div.sv */
// Restoring divider, one quotient bit per cycle.
module sedd_div #(
  parameter int NW = 40,
  parameter int VW = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt;
  logic [VW:0]      rem;
  logic [VW-1:0]    dvs;
  logic [VW:0]      trial;

  assign trial = {rem[VW-1:0], quot[NW-1]};

  // Shift in one dividend bit and subtract when it fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          quot   <= dividend;
          dvs    <= divisor;
          rem    <= '0;
          cnt    <= CNT_W'(NW);
          busy_r <= 1'b1;
        end
      end else begin
        if (trial >= {1'b0, dvs}) begin
          rem  <= trial - {1'b0, dvs};
          quot <= {quot[NW-2:0], 1'b1};
        end else begin
          rem  <= trial;
          quot <= {quot[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/sedd_front.sv */
// Front end: accepts flow items into a two-entry queue.
module sedd_front
  import sedd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  sedd_in_t   flow,
  output logic       busy,
  input  logic       pop,
  output sedd_head_t head
);

  sedd_in_t   q [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] fill;
  logic       push;

  assign busy = (fill == 2'd2);
  assign push = start && !busy;
  assign head.valid = (fill != 2'd0);
  assign head.item  = q[rd_ptr];

  // Queue storage and pointers.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= flow;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

/* hdl/sedd_back.sv */
// Back end: source table search, entropy pass and alert decision.
module sedd_back
  import sedd_pkg::*;
#(
  parameter int MAX_SOURCES = 1024,
  parameter int WINDOW_MAX  = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  sedd_head_t          head,
  output logic                pop,
  input  logic [THRESH_W-1:0] thresh,
  input  logic [MINF_W-1:0]   min_flows,
  output logic                result_valid,
  output sedd_out_t           result
);

  localparam int IW   = $clog2(MAX_SOURCES + 1);
  localparam int CW   = $clog2(WINDOW_MAX + 1);
  localparam int ROWS = (MAX_SOURCES + LANES - 1) / LANES;
  localparam int RW   = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int SW   = CW + LOG_W;
  localparam int NW   = SW > THRESH_W + 16 ? SW : THRESH_W + 16;
  localparam int VW   = CW > THRESH_W ? CW : THRESH_W;
  localparam int XW   = IW + LANE_W;

  typedef enum logic [3:0] {
    B_IDLE, B_SRCH_RD, B_SRCH_CMP, B_INS, B_LASTCHK, B_P_RD, B_P_GET,
    B_P_LOG, B_N_LOG, B_N_WAIT, B_Q_WAIT, B_H, B_C_WAIT, B_EMIT
  } bstate_t;

  bstate_t            state;
  logic [ADDR_W-1:0]  addr;
  logic               last;
  logic [IW-1:0]      du;
  logic [CW-1:0]      wf;
  logic [RW-1:0]      row;
  logic [IW-1:0]      eidx;
  logic [CW-1:0]      cval;
  logic [CW-1:0]      best_cnt;
  logic [ADDR_W-1:0]  top;
  logic [SW-1:0]      ssum;
  logic [LOG_W-1:0]   ln;
  logic [NW-1:0]      qv;
  logic [ENT_W-1:0]   h;
  logic               alert;
  logic [CONF_W-1:0]  conf;

  logic [ADDR_W-1:0]  tbl_rd [LANES];
  logic [CW-1:0]      cnt_rd [LANES];
  logic [LANES-1:0]   tbl_we, cnt_we;
  logic [RW-1:0]      raddr, waddr;
  logic [ADDR_W-1:0]  tbl_wdata;
  logic [CW-1:0]      cnt_wdata;

  logic               hit;
  logic [LANE_W-1:0]  hit_lane;
  logic [RW-1:0]      last_row;
  logic [LANE_W-1:0]  elane;
  logic [CW-1:0]      c_now;
  logic [ADDR_W-1:0]  a_now;

  logic               log_start, log_done;
  logic [CW-1:0]      log_x;
  logic [LOG_W-1:0]   log_res;
  logic               div_start, div_done;
  logic [NW-1:0]      div_n, div_q;
  logic [VW-1:0]      div_v;
  logic [LOG_W-1:0]   h_diff;
  logic [ENT_W-1:0]   h_calc;
  logic               alert_calc;

  // Source table and count banks, one pair per lane.
  for (genvar l = 0; l < LANES; l++) begin : g_bank
    sedd_ram #(.W(ADDR_W), .D(ROWS)) u_tbl (
      .clk(clk), .we(tbl_we[l]), .waddr(waddr), .wdata(tbl_wdata),
      .raddr(raddr), .rdata(tbl_rd[l])
    );
    sedd_ram #(.W(CW), .D(ROWS)) u_cnt (
      .clk(clk), .we(cnt_we[l]), .waddr(waddr), .wdata(cnt_wdata),
      .raddr(raddr), .rdata(cnt_rd[l])
    );
  end

  sedd_log #(.XW(CW)) u_log (
    .clk(clk), .rst(rst), .start(log_start), .x(log_x),
    .done(log_done), .res(log_res)
  );

  sedd_div #(.NW(NW), .VW(VW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_n),
    .divisor(div_v), .done(div_done), .quot(div_q)
  );

  // Lane compare over the row just read; first match wins.
  always_comb begin
    hit      = 1'b0;
    hit_lane = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if ((XW'({row, LANE_W'(l)}) < XW'(du)) && (tbl_rd[l] == addr)) begin
        hit      = 1'b1;
        hit_lane = LANE_W'(l);
      end
    end
    last_row = RW'((du - 1'b1) >> LANE_W);
    elane    = LANE_W'(eidx);
    c_now    = cnt_rd[elane];
    a_now    = tbl_rd[elane];
  end

  // Read address, table writes and queue pop.
  always_comb begin
    raddr     = '0;
    waddr     = row;
    tbl_we    = '0;
    cnt_we    = '0;
    tbl_wdata = addr;
    cnt_wdata = cnt_rd[hit_lane] + 1'b1;
    pop       = (state == B_IDLE) && head.valid;
    unique case (state)
      B_SRCH_RD:  raddr = row;
      B_SRCH_CMP: begin
        raddr = row + 1'b1;
        if (hit) begin
          cnt_we[hit_lane] = 1'b1;
        end
      end
      B_INS: begin
        waddr     = RW'(du >> LANE_W);
        cnt_wdata = CW'(1);
        tbl_we[LANE_W'(du)] = 1'b1;
        cnt_we[LANE_W'(du)] = 1'b1;
      end
      B_P_RD:     raddr = RW'(eidx >> LANE_W);
      default:    raddr = '0;
    endcase
  end

  // Entropy, alert test and the shared unit operands.
  always_comb begin
    h_diff     = (qv >= NW'(ln)) ? '0 : ln - LOG_W'(qv);
    h_calc     = h_diff[LOG_W-1] ? '1 : h_diff[ENT_W-1:0];
    alert_calc = (wf >= CW'(min_flows)) && (h_calc < thresh);
    log_start  = ((state == B_P_GET) && (c_now > CW'(1))) || (state == B_N_LOG);
    log_x      = (state == B_N_LOG) ? wf : c_now;
    div_start  = ((state == B_N_WAIT) && log_done && (wf != '0)) ||
                 ((state == B_H) && alert_calc);
    div_n      = (state == B_H) ? NW'({thresh - h_calc, 16'b0}) : NW'(ssum);
    div_v      = (state == B_H) ? VW'(thresh) : VW'(wf);
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      du           <= '0;
      wf           <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (head.valid) begin
            addr <= head.item.src_addr;
            last <= head.item.last_flow;
            row  <= '0;
            if (wf < CW'(WINDOW_MAX)) begin
              wf    <= wf + 1'b1;
              state <= (du == '0) ? B_INS : B_SRCH_RD;
            end else begin
              state <= B_LASTCHK;
            end
          end
        end
        B_SRCH_RD: state <= B_SRCH_CMP;
        B_SRCH_CMP: begin
          if (hit) begin
            state <= B_LASTCHK;
          end else if (row == last_row) begin
            state <= (du < IW'(MAX_SOURCES)) ? B_INS : B_LASTCHK;
          end else begin
            row <= row + 1'b1;
          end
        end
        B_INS: begin
          du    <= du + 1'b1;
          state <= B_LASTCHK;
        end
        B_LASTCHK: begin
          eidx     <= '0;
          ssum     <= '0;
          best_cnt <= '0;
          top      <= '0;
          if (!last) begin
            state <= B_IDLE;
          end else begin
            state <= (du == '0) ? B_N_LOG : B_P_RD;
          end
        end
        B_P_RD: state <= B_P_GET;
        B_P_GET: begin
          cval <= c_now;
          if (c_now > best_cnt) begin
            best_cnt <= c_now;
            top      <= a_now;
          end
          if (c_now > CW'(1)) begin
            state <= B_P_LOG;
          end else if (eidx + 1'b1 == du) begin
            state <= B_N_LOG;
          end else begin
            eidx  <= eidx + 1'b1;
            state <= B_P_RD;
          end
        end
        B_P_LOG: begin
          if (log_done) begin
            ssum <= ssum + SW'(cval * log_res);
            if (eidx + 1'b1 == du) begin
              state <= B_N_LOG;
            end else begin
              eidx  <= eidx + 1'b1;
              state <= B_P_RD;
            end
          end
        end
        B_N_LOG: state <= B_N_WAIT;
        B_N_WAIT: begin
          if (log_done) begin
            ln <= log_res;
            if (wf == '0) begin
              qv    <= '0;
              state <= B_H;
            end else begin
              state <= B_Q_WAIT;
            end
          end
        end
        B_Q_WAIT: begin
          if (div_done) begin
            qv    <= div_q;
            state <= B_H;
          end
        end
        B_H: begin
          h     <= h_calc;
          alert <= alert_calc;
          conf  <= '0;
          state <= alert_calc ? B_C_WAIT : B_EMIT;
        end
        B_C_WAIT: begin
          if (div_done) begin
            conf  <= CONF_W'(div_q);
            state <= B_EMIT;
          end
        end
        B_EMIT: begin
          result_valid            <= 1'b1;
          result.alert            <= alert;
          result.top_source       <= top;
          result.entropy_value    <= h;
          result.confidence       <= conf;
          result.flow_total       <= TOTAL_W'(wf);
          result.distinct_sources <= DIST_W'(du);
          du    <= '0;
          wf    <= '0;
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

/* hdl/source_entropy_ddos_detector_unit.sv */
// Top level: APB registers, item queue and entropy engine.
// A non-last item searches the stored sources, 16 table entries per cycle, and a new source
// is inserted while the table has room. A last item adds a walk of the table with a log2
// run per entry with count above one, a log2 of the window total N and up to two divider
// runs. The result shows for one cycle on result_valid and the receiver cannot stall.
// Reset (rst, synchronous) empties window and queue, loads defaults.
module source_entropy_ddos_detector_unit
  import sedd_pkg::*;
#(
  parameter int MAX_SOURCES = 1024,
  parameter int WINDOW_MAX  = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  sedd_in_t    flow,
  output logic        busy,
  output logic        result_valid,
  output sedd_out_t   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [THRESH_W-1:0] thresh;
  logic [MINF_W-1:0]   min_flows;
  sedd_head_t          head;
  logic                pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MINF) ? 32'(min_flows) : 32'(thresh);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh    <= THRESH_RST;
      min_flows <= MINF_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_THRESH) begin
        thresh <= pwdata[THRESH_W-1:0];
      end else begin
        min_flows <= pwdata[MINF_W-1:0];
      end
    end
  end

  sedd_front u_front (
    .clk(clk), .rst(rst), .start(start), .flow(flow), .busy(busy),
    .pop(pop), .head(head)
  );

  sedd_back #(.MAX_SOURCES(MAX_SOURCES), .WINDOW_MAX(WINDOW_MAX)) u_back (
    .clk(clk), .rst(rst), .head(head), .pop(pop), .thresh(thresh),
    .min_flows(min_flows), .result_valid(result_valid), .result(result)
  );

endmodule

/* verif/tb_source_entropy_ddos_detector_unit.sv */
// Self-checking testbench for the source entropy flood detector top level.
module tb_source_entropy_ddos_detector_unit;
  import sedd_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int WINDOW_CAP  = 4096;
  localparam int SETTLE      = 200;
  localparam int STALL_LIMIT = 400000;

  typedef enum logic [1:0] {OP_FLOW, OP_CFG, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t    kind;
    sedd_in_t    flow;
    logic        reg_sel;
    logic [31:0] value;
  } stim_op_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  sedd_in_t    flow = '0;
  logic        busy;
  logic        result_valid;
  sedd_out_t   result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  source_entropy_ddos_detector_unit dut (
    .clk(clk), .rst(rst), .start(start), .flow(flow), .busy(busy),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stimulus, expected window reports and shadow state of the detector.
  stim_op_t  pending_ops[$];
  sedd_out_t window_reports[$];
  logic [31:0] shadow_src[TABLE_DEPTH];
  int unsigned shadow_cnt[TABLE_DEPTH];
  int unsigned shadow_distinct;
  int unsigned shadow_flows;
  logic [THRESH_W-1:0] shadow_thresh = THRESH_RST;
  logic [MINF_W-1:0]   shadow_minf = MINF_RST;

  int errors = 0;
  int flows_sent = 0;
  int flows_planned = 0;
  int windows_seen = 0;
  int alerts_seen = 0;
  int cfg_writes = 0;
  int stall_cycles = 0;

  // Q.16 base-2 log by repeated squaring of the mantissa, rounded.
  function automatic logic [31:0] log2_fixed(input logic [31:0] x);
    logic [63:0]  m;
    logic [127:0] p;
    logic [31:0]  frac;
    int           e;
    if (x <= 1) return 32'd0;
    e = 0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    m = {32'b0, x} << (62 - e);
    frac = '0;
    for (int i = 0; i < 17; i++) begin
      p = {64'b0, m} * {64'b0, m};
      m = p[125:62];
      frac = frac << 1;
      if (m[63]) begin
        frac = frac | 32'd1;
        m = m >> 1;
      end
    end
    return ((32'(e) << 17 | frac) + 32'd1) >> 1;
  endfunction

  // Count one accepted flow and, on the window's last flow, queue its report.
  task automatic count_flow(input sedd_in_t f);
    logic [63:0] sum;
    logic [63:0] ln;
    logic [63:0] q;
    logic [31:0] h;
    int unsigned top_idx;
    bit found;
    sedd_out_t rep;
    if (shadow_flows < WINDOW_CAP) begin
      shadow_flows++;
      found = 1'b0;
      for (int i = 0; i < shadow_distinct; i++) begin
        if (shadow_src[i] == f.src_addr) begin
          shadow_cnt[i]++;
          found = 1'b1;
          break;
        end
      end
      if (!found && shadow_distinct < TABLE_DEPTH) begin
        shadow_src[shadow_distinct] = f.src_addr;
        shadow_cnt[shadow_distinct] = 1;
        shadow_distinct++;
      end
    end
    if (!f.last_flow) return;

    sum = '0;
    top_idx = 0;
    for (int i = 0; i < shadow_distinct; i++) begin
      sum += 64'(shadow_cnt[i]) * 64'(log2_fixed(shadow_cnt[i]));
      if (shadow_cnt[i] > shadow_cnt[top_idx]) top_idx = i;
    end
    ln = 64'(log2_fixed(shadow_flows));
    q = (shadow_flows != 0) ? sum / shadow_flows : 64'd0;
    h = (q >= ln) ? 32'd0 : 32'(ln - q);
    if (h > 32'hFFFFF) h = 32'hFFFFF;

    rep = '0;
    rep.top_source = (shadow_distinct > 0) ? shadow_src[top_idx] : '0;
    rep.entropy_value = h[ENT_W-1:0];
    if (shadow_flows >= shadow_minf && h < shadow_thresh) begin
      rep.alert = 1'b1;
      rep.confidence = CONF_W'((64'(shadow_thresh - h) << 16) / shadow_thresh);
    end
    rep.flow_total = TOTAL_W'(shadow_flows);
    rep.distinct_sources = DIST_W'(shadow_distinct);
    window_reports.push_back(rep);
    shadow_distinct = 0;
    shadow_flows = 0;
  endtask

  // Sender: flows, register writes and drain pauses in queue order.
  int drain_wait = 0;
  int idle_pct;
  always @(posedge clk) begin : sender
    logic nxt_start;
    logic nxt_psel;
    logic free;
    stim_op_t op;
    if (rst) begin
      start <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
    end else begin
      nxt_start = start;
      nxt_psel = psel;
      if (start && !busy) begin
        count_flow(flow);
        flows_sent++;
        nxt_start = 1'b0;
      end
      if (psel && penable && pready) begin
        if (paddr[2] == REG_MINF) shadow_minf = pwdata[MINF_W-1:0];
        else shadow_thresh = pwdata[THRESH_W-1:0];
        cfg_writes++;
        nxt_psel = 1'b0;
        penable <= 1'b0;
      end else if (psel) begin
        penable <= 1'b1;
      end
      free = !nxt_start && !nxt_psel;
      idle_pct = (flows_sent * 3 < flows_planned) ? 25 :
                 (flows_sent * 3 < flows_planned * 2) ? 87 : 0;
      if (free && pending_ops.size() > 0) begin
        op = pending_ops[0];
        case (op.kind)
          OP_FLOW: begin
            if ($urandom_range(99) >= idle_pct) begin
              void'(pending_ops.pop_front());
              flow <= op.flow;
              nxt_start = 1'b1;
            end
          end
          OP_CFG: begin
            void'(pending_ops.pop_front());
            nxt_psel = 1'b1;
            pwrite <= 1'b1;
            paddr <= {op.reg_sel, 2'b00};
            pwdata <= op.value;
          end
          default: begin
            // Hold off until every report is in and the block has settled.
            if (window_reports.size() == 0 && !busy) drain_wait++;
            else drain_wait = 0;
            if (drain_wait >= SETTLE) begin
              drain_wait = 0;
              void'(pending_ops.pop_front());
            end
          end
        endcase
      end
      start <= nxt_start;
      psel <= nxt_psel;
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Receiver: each report is compared with the oldest expected one.
  always @(posedge clk) begin : receiver
    sedd_out_t exp_rep;
    if (!rst && result_valid) begin
      if (window_reports.size() == 0) begin
        errors++;
        $display("%0t unexpected report: expected none actual %h", $time, result);
      end else begin
        exp_rep = window_reports.pop_front();
        windows_seen++;
        if (exp_rep.alert) alerts_seen++;
        check_field("alert", exp_rep.alert, result.alert);
        check_field("top_source", exp_rep.top_source, result.top_source);
        check_field("entropy_value", exp_rep.entropy_value, result.entropy_value);
        check_field("confidence", exp_rep.confidence, result.confidence);
        check_field("flow_total", exp_rep.flow_total, result.flow_total);
        check_field("distinct_sources", exp_rep.distinct_sources, result.distinct_sources);
      end
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (psel && penable)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d reports outstanding", window_reports.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_flow(input logic [31:0] addr, input logic last);
    stim_op_t op;
    op.kind = OP_FLOW;
    op.flow.src_addr = addr;
    op.flow.last_flow = last;
    op.reg_sel = 1'b0;
    op.value = '0;
    pending_ops.push_back(op);
    flows_planned++;
  endtask

  task automatic add_drain();
    stim_op_t op;
    op.kind = OP_DRAIN;
    op.flow = '0;
    op.reg_sel = 1'b0;
    op.value = '0;
    pending_ops.push_back(op);
  endtask

  // Register writes only follow a drain, so the block is idle.
  task automatic add_cfg(input logic [31:0] thresh, input logic [31:0] minf);
    stim_op_t op;
    add_drain();
    op.kind = OP_CFG;
    op.flow = '0;
    op.reg_sel = REG_THRESH;
    op.value = thresh;
    pending_ops.push_back(op);
    op.reg_sel = REG_MINF;
    op.value = minf;
    pending_ops.push_back(op);
  endtask

  // One window drawn from a pool of sources, skewed toward the first one.
  task automatic add_window(input int len, input int pool_size, input int skew_pct);
    logic [31:0] pool[$];
    logic [31:0] a;
    for (int i = 0; i < pool_size; i++) begin
      case ($urandom_range(9))
        0: a = 32'h0;
        1: a = 32'hFFFF_FFFF;
        default: a = $urandom;
      endcase
      pool.push_back(a);
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < skew_pct) a = pool[0];
      else a = pool[$urandom_range(pool_size - 1)];
      add_flow(a, i == len - 1);
    end
  endtask

  initial begin
    int len;
    // Directed: field extremes, single flow, skewed and flood windows.
    add_flow(32'h0, 1'b0);
    add_flow(32'hFFFF_FFFF, 1'b0);
    add_flow(32'h0, 1'b1);
    add_flow(32'h1234_5678, 1'b1);
    for (int i = 0; i < 12; i++) add_flow(32'hC0A8_0001, i == 11);
    add_cfg(655360, 1);
    add_window(6, 3, 60);
    add_cfg(0, 1);
    add_window(8, 1, 100);
    add_cfg(655360, 4096);
    // Table full: more distinct sources than the table holds.
    for (int i = 0; i < TABLE_DEPTH + 6; i++) add_flow(32'hA000_0000 + i, 1'b0);
    for (int i = 0; i < 40; i++) add_flow(32'hA000_0000 + (i % 3), 1'b0);
    add_flow(32'hBEEF_0000, 1'b1);
    add_cfg(THRESH_RST, MINF_RST);

    // Random windows with occasional register changes and full drains.
    while (flows_planned < 2000) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      add_window(len, $urandom_range(1, (len < 20) ? len : 20), $urandom_range(0, 90));
      case ($urandom_range(7))
        0: add_cfg($urandom_range(0, 655360), $urandom_range(1, 40));
        1: add_cfg($urandom_range(60000, 200000), $urandom_range(1, 4096));
        2: add_drain();
        default: ;
      endcase
    end
    add_drain();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending_ops.size() == 0 && window_reports.size() == 0);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d flows in %0d windows, %0d alerts, %0d register writes",
             flows_sent, windows_seen, alerts_seen, cfg_writes);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/sedd_pkg.sv
hdl/sedd_ram.sv
hdl/sedd_log.sv
hdl/sedd_div.sv
hdl/sedd_front.sv
hdl/sedd_back.sv
hdl/source_entropy_ddos_detector_unit.sv
verif/tb_source_entropy_ddos_detector_unit.sv
